// ===== design/contactless_reader_register_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the contactless reader register FIFO
// Shared property wrappers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CONTACTLESS_READER_REGISTER_FIFO_MACROS_SVH
`define CONTACTLESS_READER_REGISTER_FIFO_MACROS_SVH

// Condition that must hold at every clock edge
`define CRF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent
`define CRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent
`define CRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg
// Types, register map, frame bytes and helper functions of the reader front end.
// ----------------------------------------------------------------------------
package crf_pkg;

    // Geometry
    localparam int REG_COUNT       = 64;
    localparam int REG_AW          = 6;
    localparam int FIFO_DEPTH_DEF  = 64;
    localparam int MAX_BURST_DEF   = 18;
    localparam int OPCODE_W        = 2;
    localparam int UID_W           = 32;
    localparam int IDX_W           = 3;

    // Register map
    localparam logic [REG_AW-1:0] A_COMMAND    = 6'h01;
    localparam logic [REG_AW-1:0] A_IRQ        = 6'h04;
    localparam logic [REG_AW-1:0] A_FIFO_DATA  = 6'h09;
    localparam logic [REG_AW-1:0] A_FIFO_LEVEL = 6'h0A;
    localparam logic [REG_AW-1:0] A_CONTROL    = 6'h0C;
    localparam logic [REG_AW-1:0] A_BITFRAME   = 6'h0D;
    localparam logic [REG_AW-1:0] A_VERSION    = 6'h37;

    // Register values and masks
    localparam logic [7:0] VERSION_VALUE  = 8'h92;
    localparam logic [7:0] CONTROL_RESET  = 8'h80;
    localparam logic [7:0] IRQ_RX_BIT     = 8'h01;
    localparam logic [7:0] BITFRAME_KEEP  = 8'h7F;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;

    // Command register codes
    localparam logic [7:0] CMD_IDLE       = 8'h00;
    localparam logic [7:0] CMD_TRANSCEIVE = 8'h0C;
    localparam logic [7:0] CMD_SOFT_RESET = 8'h0E;

    // Card frame bytes
    localparam logic [7:0] PCD_REQA       = 8'h26;
    localparam logic [7:0] PCD_WUPA       = 8'h52;
    localparam logic [7:0] PCD_SEL_CL1    = 8'h93;
    localparam logic [7:0] NVB_ANTICOLL   = 8'h20;
    localparam logic [7:0] NVB_ALT        = 8'h26;
    localparam logic [7:0] NVB_SELECT     = 8'h94;
    localparam logic [7:0] ATQA_LOW       = 8'h04;
    localparam logic [7:0] SAK_VALUE      = 8'h08;

    localparam logic [UID_W-1:0] UID_RESET = 32'h509D_3923;

    // Transceive fetch: bytes 0..6 are read, decision at the index after the last
    localparam logic [IDX_W-1:0] XC_LAST_IDX = 3'd7;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_DESELECT = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BURST,
        S_XC_FETCH,
        S_FILL,
        S_IRQ_RD,
        S_IRQ_WR,
        S_BF_WR
    } t_state;

    // Source of the byte held in the read stage
    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_REG,
        SRC_FIFO
    } t_src;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_ATQA,
        FILL_UID,
        FILL_SAK
    } t_fill;

    typedef enum logic [1:0] {
        XC_IGNORE,
        XC_FLAGS,
        XC_REFILL
    } t_xc;

    // Register contents before the first write
    function automatic logic [7:0] reg_reset_value(input logic [REG_AW-1:0] addr);
        logic [7:0] v;
        v = ZERO_BYTE;
        if (addr == A_VERSION) begin
            v = VERSION_VALUE;
        end else if (addr == A_CONTROL) begin
            v = CONTROL_RESET;
        end
        return v;
    endfunction

    function automatic logic [IDX_W-1:0] fill_len(input t_fill kind);
        logic [IDX_W-1:0] n;
        unique case (kind)
            FILL_ATQA: n = 3'd2;
            FILL_UID:  n = 3'd5;
            FILL_SAK:  n = 3'd1;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Byte idx of a card reply
    function automatic logic [7:0] fill_byte(input t_fill kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [UID_W-1:0] uid);
        logic [7:0] b;
        b = ZERO_BYTE;
        unique case (kind)
            FILL_ATQA: b = (idx == 3'd0) ? ATQA_LOW : ZERO_BYTE;
            FILL_SAK:  b = SAK_VALUE;
            FILL_UID: begin
                unique case (idx)
                    3'd0:    b = uid[31:24];
                    3'd1:    b = uid[23:16];
                    3'd2:    b = uid[15:8];
                    3'd3:    b = uid[7:0];
                    default: b = uid[31:24] ^ uid[23:16] ^ uid[15:8] ^ uid[7:0];
                endcase
            end
            default:   b = ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== design/crf_channels.sv =====
// ----------------------------------------------------------------------------
// crf channels
// Valid/ready channels of the reader front end: access in, read data out,
// card identifier write.
// ----------------------------------------------------------------------------
interface crf_cmd_if import crf_pkg::*; ;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [REG_AW-1:0]   reg_address;
    logic [7:0]          write_byte;

    modport source (output valid, opcode, reg_address, write_byte, input ready);
    modport sink   (input valid, opcode, reg_address, write_byte, output ready);
endinterface

interface crf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       last_of_burst;
    logic       card_is_selected;

    modport source (output valid, read_byte, last_of_burst, card_is_selected, input ready);
    modport sink   (input valid, read_byte, last_of_burst, card_is_selected, output ready);
endinterface

interface crf_cfg_if import crf_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [UID_W-1:0] card_uid;

    modport source (output valid, card_uid, input ready);
    modport sink   (input valid, card_uid, output ready);
endinterface

// ===== design/contactless_reader_register_fifo.sv =====
// ----------------------------------------------------------------------------
// contactless_reader_register_fifo
// Register and FIFO front end of a contactless reader with one emulated card.
// ----------------------------------------------------------------------------
// Use:
//   i_cmd carries one register access per beat: read, write or chip select
//   released. o_rsp returns one beat per byte read, with last_of_burst on the
//   final byte and the current selected flag. i_cfg writes the card identifier
//   and is always ready; write it only while the block is idle.
// Flow:
//   A single register read gives its beat through the read stage and the output
//   beat; a write or a release gives none. A FIFO data read streams
//   min(level, MAX_BURST) beats at one per cycle while o_rsp is ready. A
//   transceive holds i_cmd while it fetches frame bytes 0..6 through the one FIFO
//   memory read port, writes a reply of up to 5 bytes and does the register RMW;
//   an ignored frame skips the reply and the RMW.
//   A new access is taken once the block is idle and its read stage is empty.
// Reset:
//   Synchronous, active low. Registers read their reset values through valid
//   bits, the FIFO is empty, the card is not selected. No clearing pass.
// Stall:
//   A stalled o_rsp holds its beat; one more byte waits in the read stage and
//   the burst sequencer holds until space frees.
// ----------------------------------------------------------------------------
module contactless_reader_register_fifo
    import crf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    parameter int MAX_BURST  = MAX_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crf_cmd_if.sink     i_cmd,
    crf_rsp_if.source   o_rsp,
    crf_cfg_if.sink     i_cfg
);

    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int SUM_W   = FIFO_AW + 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CMP_W   = (CNT_W > BURST_W) ? CNT_W : BURST_W;

    // Ring index wrap, the sum stays below twice the depth
    function automatic logic [FIFO_AW-1:0] fifo_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] depth_v;
        depth_v = SUM_W'(FIFO_DEPTH);
        if (sum >= depth_v) begin
            return FIFO_AW'(sum - depth_v);
        end
        return sum[FIFO_AW-1:0];
    endfunction

    // Control state
    t_state              r_state, n_state;
    logic [FIFO_AW-1:0]  r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [BURST_W-1:0]  r_left, n_left;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_step, n_step;
    logic                r_sel, n_sel;
    logic [UID_W-1:0]    r_uid;
    logic [REG_COUNT-1:0] r_reg_vld;

    // Transceive working registers
    logic [7:0]          r_cmd, n_cmd;
    logic [7:0]          r_second, n_second;
    logic [7:0]          r_xor, n_xor;
    t_fill               r_fill_kind, n_fill_kind;
    logic                r_do_bf, n_do_bf;

    // Memories
    logic [7:0]          r_reg_mem  [REG_COUNT];
    logic [7:0]          r_fifo_mem [FIFO_DEPTH];
    logic [7:0]          r_reg_q;
    logic [7:0]          r_fifo_q;

    // Memory strobes
    logic                reg_we, reg_re, fifo_we, fifo_re;
    logic [REG_AW-1:0]   reg_wa, reg_ra;
    logic [7:0]          reg_wd, fifo_wd;
    logic [FIFO_AW-1:0]  fifo_wa, fifo_ra;

    // Read stage (memory output) and output beat
    logic                r_q_vld;
    t_src                r_q_src;
    logic [7:0]          r_q_const;
    logic                r_q_last, r_q_sel, r_q_rvld;
    logic                q_load, q_last, q_rvld;
    t_src                q_src;
    logic [7:0]          q_const, q_byte;
    logic                r_out_vld;
    logic [7:0]          r_out_byte;
    logic                r_out_last, r_out_sel;

    logic                in_fire, move_q, q_free;

    // Transceive decision
    t_xc                 xc_action;
    t_fill               xc_kind;
    logic                xc_bf, xc_step_upd, xc_step_val, xc_sel_set;

    logic [7:0]          irq_base, bf_base;

    // Handshakes
    assign i_cmd.ready = (r_state == S_IDLE) && !r_q_vld;
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign move_q      = r_q_vld && (!r_out_vld || o_rsp.ready);
    assign q_free      = !r_q_vld || move_q;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.read_byte        = r_out_byte;
    assign o_rsp.last_of_burst    = r_out_last;
    assign o_rsp.card_is_selected = r_out_sel;

    assign irq_base = r_reg_vld[A_IRQ]      ? r_reg_q : reg_reset_value(A_IRQ);
    assign bf_base  = r_reg_vld[A_BITFRAME] ? r_reg_q : reg_reset_value(A_BITFRAME);

    // Classify the frame once bytes 0..6 are in; byte 6 sits in the FIFO read data
    always_comb begin
        xc_action   = XC_IGNORE;
        xc_kind     = FILL_NONE;
        xc_bf       = 1'b0;
        xc_step_upd = 1'b0;
        xc_step_val = 1'b0;
        xc_sel_set  = 1'b0;
        if (r_cmd == PCD_REQA || r_cmd == PCD_WUPA) begin
            xc_action   = XC_REFILL;
            xc_kind     = FILL_ATQA;
            xc_step_upd = 1'b1;
        end else if (r_cmd == PCD_SEL_CL1) begin
            if (!r_step && r_count == CNT_W'(2)
                    && (r_second == NVB_ANTICOLL || r_second == NVB_ALT)) begin
                xc_action   = XC_REFILL;
                xc_kind     = FILL_UID;
                xc_bf       = 1'b1;
                xc_step_upd = 1'b1;
                xc_step_val = 1'b1;
            end else if (r_step && r_count >= CNT_W'(9) && r_second == NVB_SELECT) begin
                xc_action = XC_REFILL;
                xc_bf     = 1'b1;
                if (r_xor == r_fifo_q) begin
                    xc_kind     = FILL_SAK;
                    xc_sel_set  = 1'b1;
                    xc_step_upd = 1'b1;
                end
            end
        end else begin
            xc_action = XC_FLAGS;
            xc_bf     = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_cmd.opcode == OP_READ && i_cmd.reg_address == A_FIFO_DATA
                            && r_count != '0) begin
                        n_state = S_BURST;
                    end else if (i_cmd.opcode == OP_WRITE && i_cmd.reg_address == A_COMMAND
                            && i_cmd.write_byte == CMD_TRANSCEIVE && r_count != '0) begin
                        n_state = S_XC_FETCH;
                    end
                end
            end
            S_BURST: begin
                if (q_free && r_left == BURST_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_XC_FETCH: begin
                if (r_idx == XC_LAST_IDX) begin
                    unique case (xc_action)
                        XC_FLAGS:  n_state = S_IRQ_RD;
                        XC_REFILL: n_state = (fill_len(xc_kind) != '0) ? S_FILL : S_IRQ_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_FILL: begin
                if (r_idx == fill_len(r_fill_kind) - IDX_W'(1)) begin
                    n_state = S_IRQ_RD;
                end
            end
            S_IRQ_RD: n_state = S_IRQ_WR;
            S_IRQ_WR: n_state = r_do_bf ? S_BF_WR : S_IDLE;
            S_BF_WR:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Strobes and datapath next values
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_left      = r_left;
        n_idx       = r_idx;
        n_step      = r_step;
        n_sel       = r_sel;
        n_cmd       = r_cmd;
        n_second    = r_second;
        n_xor       = r_xor;
        n_fill_kind = r_fill_kind;
        n_do_bf     = r_do_bf;
        reg_we      = 1'b0;
        reg_wa      = '0;
        reg_wd      = '0;
        reg_re      = 1'b0;
        reg_ra      = '0;
        fifo_we     = 1'b0;
        fifo_wa     = '0;
        fifo_wd     = '0;
        fifo_re     = 1'b0;
        fifo_ra     = '0;
        q_load      = 1'b0;
        q_src       = SRC_CONST;
        q_const     = ZERO_BYTE;
        q_last      = 1'b1;
        q_rvld      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_cmd.opcode)
                        OP_READ: begin
                            if (i_cmd.reg_address == A_FIFO_DATA && r_count != '0) begin
                                // Start a burst of min(level, MAX_BURST) bytes
                                if (CMP_W'(r_count) < CMP_W'(MAX_BURST)) begin
                                    n_left = BURST_W'(r_count);
                                end else begin
                                    n_left = BURST_W'(MAX_BURST);
                                end
                            end else begin
                                q_load = 1'b1;
                                if (i_cmd.reg_address == A_VERSION) begin
                                    q_const = VERSION_VALUE;
                                end else if (i_cmd.reg_address == A_FIFO_LEVEL) begin
                                    q_const = 8'(r_count);
                                end else if (i_cmd.reg_address == A_FIFO_DATA) begin
                                    q_const = ZERO_BYTE;
                                end else begin
                                    q_src   = SRC_REG;
                                    q_const = reg_reset_value(i_cmd.reg_address);
                                    q_rvld  = r_reg_vld[i_cmd.reg_address];
                                    reg_re  = 1'b1;
                                    reg_ra  = i_cmd.reg_address;
                                end
                            end
                        end
                        OP_WRITE: begin
                            if (i_cmd.reg_address == A_FIFO_DATA) begin
                                // Push unless full
                                if (r_count != CNT_W'(FIFO_DEPTH)) begin
                                    fifo_we = 1'b1;
                                    fifo_wa = fifo_wrap({1'b0, r_head} + SUM_W'(r_count));
                                    fifo_wd = i_cmd.write_byte;
                                    n_count = r_count + CNT_W'(1);
                                end
                            end else if (i_cmd.reg_address == A_COMMAND) begin
                                if (i_cmd.write_byte == CMD_SOFT_RESET) begin
                                    n_sel  = 1'b0;
                                    n_step = 1'b0;
                                    reg_we = 1'b1;
                                    reg_wa = A_IRQ;
                                    reg_wd = ZERO_BYTE;
                                end else if (i_cmd.write_byte == CMD_TRANSCEIVE
                                        || i_cmd.write_byte == CMD_IDLE) begin
                                    reg_we = 1'b1;
                                    reg_wa = A_COMMAND;
                                    reg_wd = ZERO_BYTE;
                                    n_idx  = '0;
                                end
                            end else begin
                                reg_we = 1'b1;
                                reg_wa = i_cmd.reg_address;
                                reg_wd = i_cmd.write_byte;
                            end
                        end
                        OP_DESELECT: n_step = 1'b0;
                        default: ;
                    endcase
                end
            end
            S_BURST: begin
                // Pop one byte whenever the read stage has room
                if (q_free) begin
                    fifo_re = 1'b1;
                    fifo_ra = r_head;
                    q_load  = 1'b1;
                    q_src   = SRC_FIFO;
                    q_last  = (r_left == BURST_W'(1));
                    n_head  = fifo_wrap({1'b0, r_head} + SUM_W'(1));
                    n_count = r_count - CNT_W'(1);
                    n_left  = r_left - BURST_W'(1);
                end
            end
            S_XC_FETCH: begin
                // Fetch byte r_idx, take in byte r_idx-1
                if (r_idx != XC_LAST_IDX) begin
                    fifo_re = 1'b1;
                    fifo_ra = fifo_wrap({1'b0, r_head} + SUM_W'(r_idx));
                    n_idx   = r_idx + IDX_W'(1);
                end
                unique case (r_idx)
                    3'd1:    n_cmd    = r_fifo_q;
                    3'd2:    n_second = r_fifo_q;
                    3'd3:    n_xor    = r_fifo_q;
                    3'd4,
                    3'd5,
                    3'd6:    n_xor    = r_xor ^ r_fifo_q;
                    3'd7: begin
                        n_do_bf = xc_bf;
                        if (xc_step_upd) begin
                            n_step = xc_step_val;
                        end
                        if (xc_sel_set) begin
                            n_sel = 1'b1;
                        end
                        if (xc_action == XC_REFILL) begin
                            n_fill_kind = xc_kind;
                            n_head      = '0;
                            n_count     = CNT_W'(fill_len(xc_kind));
                            n_idx       = '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_FILL: begin
                fifo_we = 1'b1;
                fifo_wa = FIFO_AW'(r_idx);
                fifo_wd = fill_byte(r_fill_kind, r_idx, r_uid);
                n_idx   = r_idx + IDX_W'(1);
            end
            S_IRQ_RD: begin
                reg_re = 1'b1;
                reg_ra = A_IRQ;
            end
            S_IRQ_WR: begin
                reg_we = 1'b1;
                reg_wa = A_IRQ;
                reg_wd = irq_base | IRQ_RX_BIT;
                reg_re = r_do_bf;
                reg_ra = A_BITFRAME;
            end
            S_BF_WR: begin
                reg_we = 1'b1;
                reg_wa = A_BITFRAME;
                reg_wd = bf_base & BITFRAME_KEEP;
            end
            default: ;
        endcase
    end

    // Select the byte held in the read stage
    always_comb begin
        unique case (r_q_src)
            SRC_FIFO: q_byte = r_fifo_q;
            SRC_REG:  q_byte = r_q_rvld ? r_reg_q : r_q_const;
            default:  q_byte = r_q_const;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_left    <= '0;
            r_idx     <= '0;
            r_step    <= 1'b0;
            r_sel     <= 1'b0;
            r_uid     <= UID_RESET;
            r_reg_vld <= '0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_left  <= n_left;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_sel   <= n_sel;
            if (i_cfg.valid) begin
                r_uid <= i_cfg.card_uid;
            end
            if (reg_we) begin
                r_reg_vld[reg_wa] <= 1'b1;
            end
            // Advance the read stage and the output beat
            if (q_load) begin
                r_q_vld <= 1'b1;
            end else if (move_q) begin
                r_q_vld <= 1'b0;
            end
            if (move_q) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_second    <= n_second;
        r_xor       <= n_xor;
        r_fill_kind <= n_fill_kind;
        r_do_bf     <= n_do_bf;
        if (q_load) begin
            r_q_src   <= q_src;
            r_q_const <= q_const;
            r_q_last  <= q_last;
            r_q_sel   <= r_sel;
            r_q_rvld  <= q_rvld;
        end
        if (move_q) begin
            r_out_byte <= q_byte;
            r_out_last <= r_q_last;
            r_out_sel  <= r_q_sel;
        end
    end

    // Register file memory
    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_reg_mem[reg_wa] <= reg_wd;
        end
        if (reg_re) begin
            r_reg_q <= r_reg_mem[reg_ra];
        end
    end

    // FIFO ring memory
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo_mem[fifo_wa] <= fifo_wd;
        end
        if (fifo_re) begin
            r_fifo_q <= r_fifo_mem[fifo_ra];
        end
    end

    `include "contactless_reader_register_fifo_macros.svh"

    `CRF_ASSERT_ALWAYS(a_level_in_range, r_count <= CNT_W'(FIFO_DEPTH), "FIFO level overrun")
    `CRF_ASSERT_SAME(a_burst_nonempty, r_state == S_BURST, r_left != '0, "burst with no bytes")
    `CRF_ASSERT_NEXT(a_burst_ends, r_state == S_BURST && q_free && r_left == BURST_W'(1), r_state == S_IDLE && r_q_vld && r_q_last, "burst end lost")
    `CRF_ASSERT_SAME(a_fill_kind, r_state == S_FILL, r_fill_kind != FILL_NONE, "empty reply written")

endmodule

// ===== tb/sv/tb_contactless_reader_register_fifo.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contactless_reader_register_fifo
// Drives register accesses into the reader front end and checks every read
// beat against a shadow copy of the registers, the FIFO ring and the card
// state. A directed opening covers the FIFO extremes, the command codes and
// the card frames. Randomised activation sequences and noise follow under
// several card identifiers, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_contactless_reader_register_fifo;
    import crf_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  OP_RESERVED   = 2'd3;
    localparam logic [7:0]  CMD_UNUSED    = 8'h3F;
    localparam logic [7:0]  FRAME_UNKNOWN = 8'h55;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       sel;
    } t_beat;

    // Shadow of the front end: registers, FIFO ring, card state, owed beats
    class card_reader_shadow;
        logic [7:0]  regs [REG_COUNT];
        logic [7:0]  ring [FIFO_DEPTH_DEF];
        int          head;
        int          level;
        bit          step;
        bit          selected;
        logic [31:0] uid;
        t_beat       owed [$];
        int          fails;
        int          beats;
        int          transceives;
        int          selects;

        function new();
            for (int k = 0; k < REG_COUNT; k++) regs[k] = 8'h00;
            for (int k = 0; k < FIFO_DEPTH_DEF; k++) ring[k] = 8'h00;
            regs[A_VERSION] = VERSION_VALUE;
            regs[A_CONTROL] = CONTROL_RESET;
            head = 0;
            level = 0;
            step = 1'b0;
            selected = 1'b0;
            uid = UID_RESET;
            fails = 0;
            beats = 0;
            transceives = 0;
            selects = 0;
        endfunction

        function void set_uid(logic [31:0] value);
            uid = value;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function logic [7:0] peek(int i);
            return ring[(head + i) % FIFO_DEPTH_DEF];
        endfunction

        // Replace the FIFO with the first n bytes of reply, oldest in the top byte
        function void refill(logic [39:0] reply, int n);
            head = 0;
            for (int k = 0; k < n; k++) ring[k] = reply[39 - 8 * k -: 8];
            level = n;
            regs[A_FIFO_LEVEL] = 8'(n);
        endfunction

        // Answer the FIFO frame as the emulated card would
        function void run_transceive();
            logic [7:0] lead;
            logic [7:0] nvb;
            logic [7:0] check;
            logic [7:0] bcc;
            transceives++;
            if (level == 0) return;
            lead = peek(0);
            if (lead == PCD_REQA || lead == PCD_WUPA) begin
                refill({ATQA_LOW, ZERO_BYTE, 24'h0}, 2);
                regs[A_IRQ] |= IRQ_RX_BIT;
                step = 1'b0;
                return;
            end
            if (lead == PCD_SEL_CL1) begin
                nvb = peek(1);
                if (!step && level == 2 && (nvb == NVB_ANTICOLL || nvb == NVB_ALT)) begin
                    bcc = uid[31:24] ^ uid[23:16] ^ uid[15:8] ^ uid[7:0];
                    refill({uid, bcc}, 5);
                    step = 1'b1;
                end else if (step && level >= 9 && nvb == NVB_SELECT) begin
                    check = peek(2) ^ peek(3) ^ peek(4) ^ peek(5);
                    if (check == peek(6)) begin
                        refill({SAK_VALUE, 32'h0}, 1);
                        selected = 1'b1;
                        step = 1'b0;
                        selects++;
                    end else begin
                        refill(40'h0, 0);
                    end
                end else begin
                    return;
                end
            end
            regs[A_IRQ] |= IRQ_RX_BIT;
            regs[A_BITFRAME] &= BITFRAME_KEEP;
        endfunction

        // Advance the shadow by one accepted access and queue the beats it owes
        function void note_access(logic [1:0] op, logic [5:0] addr, logic [7:0] data);
            int         n;
            logic [7:0] v;
            if (op == OP_READ) begin
                if (addr == A_FIFO_DATA && level != 0) begin
                    n = (level < MAX_BURST_DEF) ? level : MAX_BURST_DEF;
                    for (int k = 0; k < n; k++) owed.push_back({peek(k), k == n - 1, selected});
                    head = (head + n) % FIFO_DEPTH_DEF;
                    level -= n;
                    regs[A_FIFO_LEVEL] = 8'(level);
                end else begin
                    if (addr == A_VERSION) v = VERSION_VALUE;
                    else if (addr == A_FIFO_LEVEL) v = 8'(level);
                    else if (addr == A_FIFO_DATA) v = ZERO_BYTE;
                    else v = regs[addr];
                    owed.push_back({v, 1'b1, selected});
                end
            end else if (op == OP_WRITE) begin
                if (addr == A_FIFO_DATA) begin
                    if (level < FIFO_DEPTH_DEF) begin
                        ring[(head + level) % FIFO_DEPTH_DEF] = data;
                        level++;
                        regs[A_FIFO_LEVEL] = 8'(level);
                    end
                end else if (addr == A_COMMAND) begin
                    if (data == CMD_SOFT_RESET) begin
                        selected = 1'b0;
                        step = 1'b0;
                        regs[A_IRQ] = ZERO_BYTE;
                    end else if (data == CMD_TRANSCEIVE) begin
                        run_transceive();
                        regs[A_COMMAND] = ZERO_BYTE;
                    end else if (data == CMD_IDLE) begin
                        regs[A_COMMAND] = ZERO_BYTE;
                    end
                end else begin
                    regs[addr] = data;
                end
            end else if (op == OP_DESELECT) begin
                step = 1'b0;
            end
        endfunction

        function void complain(string what);
            fails++;
            if (fails <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // Compare one read beat with the oldest owed beat
        function void check_beat(logic [7:0] data, logic last, logic sel);
            t_beat want;
            beats++;
            if (owed.size() == 0) begin
                complain($sformatf("unexpected beat data=%h last=%b sel=%b", data, last, sel));
                return;
            end
            want = owed.pop_front();
            if (want.data !== data || want.last !== last || want.sel !== sel)
                complain($sformatf("expected data=%h last=%b sel=%b, got data=%h last=%b sel=%b",
                                   want.data, want.last, want.sel, data, last, sel));
        endfunction

        function void close_out();
            if (owed.size() != 0) complain($sformatf("%0d beats never arrived", owed.size()));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    crf_cmd_if cmd_ch ();
    crf_rsp_if rsp_ch ();
    crf_cfg_if cfg_ch ();

    card_reader_shadow shadow;
    bit                calm;
    int                accesses;
    int                uid_writes;
    int                cycles;

    contactless_reader_register_fifo u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Stall the read channel now and then, never while calm
    always @(negedge i_clk) begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 9);
    end

    // Check every read beat
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow.check_beat(rsp_ch.read_byte, rsp_ch.last_of_burst, rsp_ch.card_is_selected);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL contactless_reader_register_fifo");
            $finish;
        end
    end

    // One access beat; entered and left at a falling edge
    task automatic put_access(input logic [1:0] op, input logic [5:0] addr,
                              input logic [7:0] data);
        while (!calm && $urandom_range(99) < 9) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.reg_address <= addr;
        cmd_ch.write_byte  <= data;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        shadow.note_access(op, addr, data);
        if (op != OP_RESERVED) accesses++;
        @(negedge i_clk);
    endtask

    // Hold the access channel until every owed beat is in and the block settles
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_uid(input logic [31:0] value);
        wait_idle();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.card_uid <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        shadow.set_uid(value);
        uid_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] value);
        put_access(OP_WRITE, A_FIFO_DATA, value);
    endtask

    task automatic start_transceive();
        put_access(OP_WRITE, A_COMMAND, CMD_TRANSCEIVE);
    endtask

    task automatic read_reg(input logic [5:0] addr);
        put_access(OP_READ, addr, 8'($urandom));
    endtask

    task automatic drain_fifo();
        while (shadow.level > 0) read_reg(A_FIFO_DATA);
    endtask

    task automatic card_request(input bit wake);
        drain_fifo();
        push_byte(wake ? PCD_WUPA : PCD_REQA);
        start_transceive();
        read_reg(A_FIFO_LEVEL);
        read_reg(A_FIFO_DATA);
    endtask

    task automatic card_anticoll(input bit alt);
        drain_fifo();
        push_byte(PCD_SEL_CL1);
        push_byte(alt ? NVB_ALT : NVB_ANTICOLL);
        start_transceive();
        read_reg(A_FIFO_DATA);
    endtask

    // Select frame: SEL, NVB, four id bytes, check byte, two or three trailer bytes
    task automatic card_select(input bit good_bcc);
        logic [31:0] id;
        logic [7:0]  bcc;
        id = ($urandom_range(99) < 80) ? shadow.uid : $urandom;
        bcc = id[31:24] ^ id[23:16] ^ id[15:8] ^ id[7:0];
        if (!good_bcc) bcc ^= 8'(1 << $urandom_range(7));
        drain_fifo();
        push_byte(PCD_SEL_CL1);
        push_byte(NVB_SELECT);
        push_byte(id[31:24]);
        push_byte(id[23:16]);
        push_byte(id[15:8]);
        push_byte(id[7:0]);
        push_byte(bcc);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        if ($urandom_range(9) == 0) push_byte(8'($urandom));
        start_transceive();
        read_reg(A_IRQ);
        read_reg(A_FIFO_DATA);
    endtask

    // Full card activation, now and then broken between anticollision and select
    task automatic card_activation();
        int roll;
        card_request($urandom_range(1));
        card_anticoll($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 12) put_access(OP_DESELECT, 6'($urandom), 8'($urandom));
        else if (roll < 20) put_access(OP_WRITE, A_COMMAND, CMD_SOFT_RESET);
        else if (roll < 26) push_byte(8'($urandom));
        card_select($urandom_range(99) < 80);
        if ($urandom_range(3) == 0) read_reg(A_BITFRAME);
    endtask

    task automatic noise_access();
        int         roll;
        logic [1:0] op;
        logic [5:0] addr;
        logic [7:0] data;
        roll = $urandom_range(99);
        if (roll < 40) op = OP_READ;
        else if (roll < 80) op = OP_WRITE;
        else if (roll < 92) op = OP_DESELECT;
        else op = OP_RESERVED;
        case ($urandom_range(13))
            0:       addr = A_COMMAND;
            1:       addr = A_IRQ;
            2, 3:    addr = A_FIFO_DATA;
            4:       addr = A_FIFO_LEVEL;
            5:       addr = A_CONTROL;
            6:       addr = A_BITFRAME;
            7:       addr = A_VERSION;
            default: addr = 6'($urandom);
        endcase
        data = 8'($urandom);
        if (addr == A_COMMAND && $urandom_range(99) < 70) begin
            case ($urandom_range(2))
                0:       data = CMD_IDLE;
                1:       data = CMD_TRANSCEIVE;
                default: data = CMD_SOFT_RESET;
            endcase
        end
        put_access(op, addr, data);
    endtask

    task automatic run_random(input int quota);
        int stop_at;
        int roll;
        stop_at = accesses + quota;
        while (accesses < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 12) card_request($urandom_range(1));
            else if (roll < 24) card_anticoll($urandom_range(1));
            else if (roll < 55) card_activation();
            else noise_access();
        end
    endtask

    task automatic run_directed();
        // Fill every FIFO slot, overfill, then drain in bursts and read once empty
        for (int k = 0; k < FIFO_DEPTH_DEF; k++) push_byte(8'($urandom));
        push_byte(8'hFF);
        read_reg(A_FIFO_LEVEL);
        drain_fifo();
        read_reg(A_FIFO_DATA);
        read_reg(A_VERSION);
        read_reg(A_CONTROL);
        read_reg(A_IRQ);
        // Command register codes
        put_access(OP_WRITE, A_COMMAND, CMD_UNUSED);
        read_reg(A_COMMAND);
        put_access(OP_WRITE, A_COMMAND, CMD_IDLE);
        read_reg(A_COMMAND);
        start_transceive();
        read_reg(A_IRQ);
        // Plain registers at the address extremes
        put_access(OP_WRITE, 6'h3F, 8'hFF);
        read_reg(6'h3F);
        put_access(OP_WRITE, 6'h00, 8'h00);
        put_access(OP_WRITE, A_VERSION, 8'h00);
        read_reg(A_VERSION);
        put_access(OP_WRITE, A_FIFO_LEVEL, 8'hFF);
        read_reg(A_FIFO_LEVEL);
        put_access(OP_WRITE, A_BITFRAME, 8'hFF);
        // Card frames: request, wake, anticollision, bad then good select
        card_request(1'b0);
        read_reg(A_BITFRAME);
        card_request(1'b1);
        card_anticoll(1'b0);
        card_select(1'b0);
        card_select(1'b1);
        read_reg(A_VERSION);
        // Unknown frame byte, anticollision with a wrong length
        drain_fifo();
        push_byte(FRAME_UNKNOWN);
        start_transceive();
        read_reg(A_FIFO_DATA);
        push_byte(PCD_SEL_CL1);
        push_byte(NVB_ANTICOLL);
        push_byte(NVB_ANTICOLL);
        start_transceive();
        read_reg(A_FIFO_LEVEL);
        // Release, soft reset, reserved opcode
        card_anticoll(1'b1);
        put_access(OP_DESELECT, 6'h3F, 8'hFF);
        card_select(1'b1);
        put_access(OP_WRITE, A_COMMAND, CMD_SOFT_RESET);
        read_reg(A_IRQ);
        put_access(OP_RESERVED, 6'h3F, 8'hFF);
        read_reg(A_FIFO_DATA);
    endtask

    initial begin
        shadow             = new();
        calm               = 1'b0;
        accesses           = 0;
        uid_writes         = 0;
        cycles             = 0;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = OP_READ;
        cmd_ch.reg_address = '0;
        cmd_ch.write_byte  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.card_uid    = '0;
        rsp_ch.ready       = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        write_uid(32'h0000_0000);
        run_random(15);

        // No idling anywhere for this stretch
        write_uid(32'hFFFF_FFFF);
        calm = 1'b1;
        run_random(25);
        calm = 1'b0;

        write_uid($urandom);
        run_random(10);
        wait_idle();
        run_random(10);

        write_uid($urandom);
        run_random(15);

        wait_idle();
        shadow.close_out();
        $display("Ran %0d accesses and checked %0d read beats under %0d identifiers.",
                 accesses, shadow.beats, uid_writes + 1);
        $display("Transceives: %0d, of which %0d selected the card; %0d mismatches.",
                 shadow.transceives, shadow.selects, shadow.fails);
        if (shadow.fails == 0) begin
            $display("PASS contactless_reader_register_fifo");
        end else begin
            $display("FAIL contactless_reader_register_fifo");
        end
        $finish;
    end

endmodule

// ===== contactless_reader_register_fifo.f =====
+incdir+design
design/crf_pkg.sv
design/crf_channels.sv
design/contactless_reader_register_fifo.sv
tb/sv/tb_contactless_reader_register_fifo.sv
